// ===== rtl/pbx_pkg.sv =====
// shared types, codes and helpers for the page buffer with scrambler
`default_nettype none

package pbx_pkg;

    localparam int BLOCK_BYTES_DEF = 2048;
    localparam int CMD_FIFO_DEPTH  = 4;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int AMOUNT_W = 12;
    localparam int RES_W    = 12;
    localparam int WORD_W   = 16;

    localparam logic [WORD_W-1:0] SCRAMBLE_SEED = 16'hACE1;
    localparam logic [BYTE_W-1:0] ERASED_BYTE   = 8'hFF;

    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SKIP     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REWIND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SCRAMBLE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_WRITE,
        OP_SCRAMBLE,
        OP_READ
    } mem_op_t;

    typedef enum logic {
        BK_RUN,
        BK_SWEEP
    } back_state_t;

    typedef struct packed {
        logic             ok;
        logic [RES_W-1:0] offset_now;
        logic [RES_W-1:0] bytes_left;
    } res_t;

    typedef struct packed {
        mem_op_t           op;
        logic              lane;
        logic [BYTE_W-1:0] data;
        res_t              res;
    } cmd_t;

    // one xorshift16 step, zero is forced to one first
    function automatic logic [WORD_W-1:0] next_term(input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] v;
        v = value;
        if (v == '0)
        begin
            v = 16'h0001;
        end
        v = v ^ ((v & 16'h07FF) << 5);
        v = v ^ (v >> 7);
        v = v ^ ((v & 16'h0003) << 14);
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pbx_if.sv =====
// request and response channel interfaces
`default_nettype none

interface pbx_req_if import pbx_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, kind, data_byte, amount, input ready);
    modport sink   (input valid, kind, data_byte, amount, output ready);
endinterface

interface pbx_rsp_if import pbx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [RES_W-1:0]  offset_now;
    logic [RES_W-1:0]  bytes_left;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, ok, offset_now, bytes_left, read_data, input ready);
    modport sink   (input valid, ok, offset_now, bytes_left, read_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/page_buffer_with_xorshift_scrambler_top.sv =====
// top level of the page buffer with xorshift16 scrambler
//
// A page of BLOCK_BYTES bytes held as 16-bit little-endian words, with a byte
// offset pointer. Each request beat gives exactly one response beat, in order.
// Write, read, skip and rewind items stream at one per cycle while the queue has
// room and responses are taken; the front end updates the offset as it takes
// them, and the back end carries them out on a one-write, one-read page memory
// with a registered read port. A clear or a scramble holds the back end while it
// sweeps the whole page, one word per cycle through that memory; meanwhile the
// front end keeps taking items until its CMD_DEPTH-entry queue is full. With
// nothing waiting, a request beat passes through the queue, the p1 stage and the
// output register before its response beat is offered.
// Page contents are undefined after reset until cleared or written.
`default_nettype none

module page_buffer_with_xorshift_scrambler_top import pbx_pkg::*; #(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int CMD_DEPTH   = CMD_FIFO_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pbx_req_if.sink   req,
    pbx_rsp_if.source rsp
);

    localparam int STORE_WORDS = (BLOCK_BYTES + 1) / 2;
    localparam int WA = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int QW = WA + $bits(cmd_t);

    logic          fifo_full;
    logic          cmd_push;
    cmd_t          front_cmd;
    logic [WA-1:0] front_addr;
    logic          cmd_valid;
    logic          cmd_pop;
    logic [QW-1:0] q_out;
    cmd_t          back_cmd;
    logic [WA-1:0] back_addr;

    pbx_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .fifo_full (fifo_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd),
        .cmd_addr  (front_addr)
    );

    pbx_cmd_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .din       ({front_addr, front_cmd}),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .dout      (q_out)
    );

    assign back_cmd  = q_out[$bits(cmd_t)-1:0];
    assign back_addr = q_out[QW-1:$bits(cmd_t)];

    pbx_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (back_cmd),
        .cmd_addr  (back_addr),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/pbx_front.sv =====
// front end: takes request beats, keeps the byte offset, classifies each item
`default_nettype none

module pbx_front import pbx_pkg::*; #(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    localparam int STORE_WORDS = (BLOCK_BYTES + 1) / 2,
    localparam int WA = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pbx_req_if.sink        req,
    input  wire logic      fifo_full,
    output logic           cmd_push,
    output cmd_t           cmd,
    output logic [WA-1:0]  cmd_addr
);

    localparam int OFS_W = $clog2(BLOCK_BYTES + 1);
    localparam int CMP_W = ((OFS_W > AMOUNT_W) ? OFS_W : AMOUNT_W) + 1;

    logic [OFS_W-1:0] ofs_reg;
    logic [OFS_W-1:0] ofs_next;
    logic [CMP_W-1:0] ofs_x;
    logic [CMP_W-1:0] amt_x;
    logic [CMP_W-1:0] sum_x;
    logic [CMP_W-1:0] blk_x;
    logic [CMP_W-1:0] new_x;
    logic [CMP_W-1:0] left_x;
    logic             ok;
    mem_op_t          op;
    logic             accept;

    assign req.ready = !fifo_full;
    assign accept    = req.valid && req.ready;

    assign ofs_x = CMP_W'(ofs_reg);
    assign amt_x = CMP_W'(req.amount);
    assign sum_x = ofs_x + amt_x;
    assign blk_x = CMP_W'(BLOCK_BYTES);

    always_comb
    begin
        ok       = 1'b0;
        op       = OP_NONE;
        ofs_next = ofs_reg;
        case (req.kind)
            KIND_CLEAR:
            begin
                ok       = 1'b1;
                op       = OP_CLEAR;
                ofs_next = '0;
            end
            KIND_WRITE:
            begin
                // the whole remaining run has to fit
                if (amt_x != '0 && sum_x <= blk_x)
                begin
                    ok       = 1'b1;
                    op       = OP_WRITE;
                    ofs_next = ofs_reg + OFS_W'(1);
                end
            end
            KIND_SKIP:
            begin
                if (sum_x < blk_x)
                begin
                    ok       = 1'b1;
                    ofs_next = OFS_W'(sum_x);
                end
            end
            KIND_REWIND:
            begin
                if (amt_x <= ofs_x)
                begin
                    ok       = 1'b1;
                    ofs_next = OFS_W'(amt_x);
                end
            end
            KIND_SCRAMBLE:
            begin
                ok = 1'b1;
                op = OP_SCRAMBLE;
            end
            KIND_READ:
            begin
                if (ofs_x < blk_x)
                begin
                    ok = 1'b1;
                    op = OP_READ;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign new_x  = CMP_W'(ofs_next);
    assign left_x = blk_x - new_x;

    assign cmd_push           = accept;
    assign cmd.op             = op;
    assign cmd.lane           = ofs_reg[0];
    assign cmd.data           = req.data_byte;
    assign cmd.res.ok         = ok;
    assign cmd.res.offset_now = new_x[RES_W-1:0];
    assign cmd.res.bytes_left = left_x[RES_W-1:0];
    assign cmd_addr           = WA'(ofs_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg <= '0;
        end
        else if (accept)
        begin
            ofs_reg <= ofs_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pbx_cmd_fifo.sv =====
// short command queue between front and back
`default_nettype none

module pbx_cmd_fifo import pbx_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      dout
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign dout      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pbx_back.sv =====
// back end: page memory, clear and scramble sweeps, response register
`default_nettype none

module pbx_back import pbx_pkg::*; #(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    localparam int STORE_WORDS = (BLOCK_BYTES + 1) / 2,
    localparam int WA = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire cmd_t          cmd,
    input  wire logic [WA-1:0] cmd_addr,
    output logic               cmd_pop,
    pbx_rsp_if.source          rsp
);

    localparam int CW = $clog2(STORE_WORDS + 1);

    // page memory, one array per byte lane
    logic [BYTE_W-1:0] lo_mem [STORE_WORDS];
    logic [BYTE_W-1:0] hi_mem [STORE_WORDS];
    logic [BYTE_W-1:0] rd_lo_reg;
    logic [BYTE_W-1:0] rd_hi_reg;

    logic              we_lo;
    logic              we_hi;
    logic [WA-1:0]     waddr;
    logic [BYTE_W-1:0] wdata_lo;
    logic [BYTE_W-1:0] wdata_hi;
    logic              rd_en;
    logic [WA-1:0]     raddr;

    back_state_t       state_reg;
    back_state_t       state_next;
    mem_op_t           sweep_op_reg;
    mem_op_t           sweep_op_next;
    res_t              sweep_res_reg;
    res_t              sweep_res_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              wr_pend_reg;
    logic              wr_pend_next;
    logic [WA-1:0]     wr_addr_reg;
    logic [WA-1:0]     wr_addr_next;
    logic [WORD_W-1:0] term_reg;
    logic [WORD_W-1:0] term_next;
    logic [WORD_W-1:0] scr_word;

    logic              p1_valid_reg;
    logic              p1_valid_next;
    logic              p1_load;
    res_t              p1_res_reg;
    res_t              p1_res_next;
    logic              p1_read_reg;
    logic              p1_read_next;
    logic              p1_lane_reg;
    logic              p1_lane_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              out_res_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;

    logic              out_free;
    logic              p1_move;
    logic              p1_free;
    logic              sweep_last;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign p1_move    = p1_valid_reg && out_free;
    assign p1_free    = !p1_valid_reg || p1_move;
    assign scr_word   = {rd_hi_reg, rd_lo_reg} ^ term_reg;
    assign sweep_last = (cnt_reg == CW'(STORE_WORDS)) && !wr_pend_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_op_next  = sweep_op_reg;
        sweep_res_next = sweep_res_reg;
        cnt_next       = cnt_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        term_next      = term_reg;
        cmd_pop        = 1'b0;
        p1_load        = 1'b0;
        p1_res_next    = p1_res_reg;
        p1_read_next   = 1'b0;
        p1_lane_next   = p1_lane_reg;
        we_lo          = 1'b0;
        we_hi          = 1'b0;
        waddr          = cmd_addr;
        wdata_lo       = cmd.data;
        wdata_hi       = cmd.data;
        rd_en          = 1'b0;
        raddr          = cmd_addr;
        case (state_reg)
            BK_RUN:
            begin
                // the response slot must be free so read data is not overrun
                cmd_pop = cmd_valid && p1_free;
                if (cmd_pop)
                begin
                    case (cmd.op)
                        OP_CLEAR, OP_SCRAMBLE:
                        begin
                            state_next     = BK_SWEEP;
                            sweep_op_next  = cmd.op;
                            sweep_res_next = cmd.res;
                            cnt_next       = '0;
                            term_next      = SCRAMBLE_SEED;
                        end
                        OP_WRITE:
                        begin
                            we_lo        = !cmd.lane;
                            we_hi        = cmd.lane;
                            p1_load      = 1'b1;
                            p1_res_next  = cmd.res;
                        end
                        OP_READ:
                        begin
                            rd_en        = 1'b1;
                            p1_load      = 1'b1;
                            p1_res_next  = cmd.res;
                            p1_read_next = 1'b1;
                            p1_lane_next = cmd.lane;
                        end
                        default:
                        begin
                            p1_load     = 1'b1;
                            p1_res_next = cmd.res;
                        end
                    endcase
                end
            end
            BK_SWEEP:
            begin
                if (sweep_op_reg == OP_CLEAR)
                begin
                    if (cnt_reg < CW'(STORE_WORDS))
                    begin
                        we_lo    = 1'b1;
                        we_hi    = 1'b1;
                        waddr    = WA'(cnt_reg);
                        wdata_lo = ERASED_BYTE;
                        wdata_hi = ERASED_BYTE;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    // read word n while word n-1 is written back
                    if (cnt_reg < CW'(STORE_WORDS))
                    begin
                        rd_en        = 1'b1;
                        raddr        = WA'(cnt_reg);
                        wr_pend_next = 1'b1;
                        wr_addr_next = WA'(cnt_reg);
                        cnt_next     = cnt_reg + CW'(1);
                    end
                    if (wr_pend_reg)
                    begin
                        we_lo     = 1'b1;
                        we_hi     = 1'b1;
                        waddr     = wr_addr_reg;
                        wdata_lo  = scr_word[BYTE_W-1:0];
                        wdata_hi  = scr_word[WORD_W-1:BYTE_W];
                        term_next = next_term(term_reg);
                    end
                end
                if (sweep_last)
                begin
                    state_next  = BK_RUN;
                    p1_load     = 1'b1;
                    p1_res_next = sweep_res_reg;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        if (p1_load)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_move)
        begin
            p1_valid_next = 1'b0;
        end
        else
        begin
            p1_valid_next = p1_valid_reg;
        end

        if (p1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (!p1_read_reg)
        begin
            out_byte_next = '0;
        end
        else if (p1_lane_reg)
        begin
            out_byte_next = rd_hi_reg;
        end
        else
        begin
            out_byte_next = rd_lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            sweep_op_reg  <= OP_NONE;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_op_reg  <= sweep_op_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= wr_pend_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_res_reg <= sweep_res_next;
        wr_addr_reg   <= wr_addr_next;
        term_reg      <= term_next;
        if (p1_load)
        begin
            p1_res_reg  <= p1_res_next;
            p1_read_reg <= p1_read_next;
            p1_lane_reg <= p1_lane_next;
        end
        if (p1_move)
        begin
            out_res_reg  <= p1_res_reg;
            out_byte_reg <= out_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_lo)
        begin
            lo_mem[waddr] <= wdata_lo;
        end
        if (rd_en)
        begin
            rd_lo_reg <= lo_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_hi)
        begin
            hi_mem[waddr] <= wdata_hi;
        end
        if (rd_en)
        begin
            rd_hi_reg <= hi_mem[raddr];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_res_reg.ok;
    assign rsp.offset_now = out_res_reg.offset_now;
    assign rsp.bytes_left = out_res_reg.bytes_left;
    assign rsp.read_data  = out_byte_reg;

endmodule

`default_nettype wire
